// ----- sv/sobel_pkg.sv -----
// Shared types, constants and the per-channel Sobel kernel for the RGB edge filter.
// No dependencies; imported by every module of the block except sobel_ram.
package sobel_pkg;

  localparam int FRAME_WIDTH_RST  = 640;
  localparam int FRAME_HEIGHT_RST = 480;
  localparam int WIDTH_REG_W      = 11;
  localparam int HEIGHT_REG_W     = 13;
  localparam int CFG_DATA_W       = 13;
  localparam int OBUF_DEPTH       = 4;
  localparam int OBUF_CNT_W       = 3;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [7:0] chan_t;

  // red in the lowest byte, blue in the highest
  typedef struct packed {
    chan_t blue;
    chan_t green;
    chan_t red;
  } pixel_t;

  typedef pixel_t [2:0] win_row_t;
  typedef win_row_t [2:0] window_t;   // [row top..bottom][col left..right]

  typedef struct packed {
    logic valid;
    logic emit;
    logic interior;
    logic eof;
  } stage_ctrl_t;

  function automatic chan_t sobel_chan(input chan_t a00, input chan_t a01, input chan_t a02,
                                       input chan_t a10, input chan_t a12,
                                       input chan_t a20, input chan_t a21, input chan_t a22);
    logic [9:0] gx_p;
    logic [9:0] gx_n;
    logic [9:0] gy_p;
    logic [9:0] gy_n;
    logic [9:0] dx;
    logic [9:0] dy;
    chan_t      cx;
    chan_t      cy;
    logic [8:0] sum;
    gx_p = {2'b00, a00} + {1'b0, a10, 1'b0} + {2'b00, a20};
    gx_n = {2'b00, a02} + {1'b0, a12, 1'b0} + {2'b00, a22};
    gy_p = {2'b00, a00} + {1'b0, a01, 1'b0} + {2'b00, a02};
    gy_n = {2'b00, a20} + {1'b0, a21, 1'b0} + {2'b00, a22};
    dx = gx_p - gx_n;
    dy = gy_p - gy_n;
    if (gx_p <= gx_n) cx = 8'h00;
    else if (dx > 10'd255) cx = 8'hFF;
    else cx = dx[7:0];
    if (gy_p <= gy_n) cy = 8'h00;
    else if (dy > 10'd255) cy = 8'hFF;
    else cy = dy[7:0];
    sum = {1'b0, cx} + {1'b0, cy};
    return sum[8:1];
  endfunction

endpackage

// ----- sv/sobel_rgb_edge_filter_top.sv -----
// Streaming 3x3 Sobel edge filter on RGB pixels, one pixel per clock while in_tready is high.
// A result passes the line-store read stage and the window register, then waits in the queue;
// its window completes with the beat that arrives frame_width+1 beats after the pixel itself.
// Throughput: one beat per cycle while in_tready is high, set by the single read-modify-write of each line-store RAM.
// Reset (rst_n, synchronous): counters, window, queue cleared; width 640, height 480.
// Line stores are not cleared; unwritten entries never reach an emitted result.
module sobel_rgb_edge_filter_top
  import sobel_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [23:0]           in_tdata,   // pixel_red, pixel_green, pixel_blue
  input  logic                  in_tuser,   // start_of_frame
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata,  // out_red, out_green, out_blue
  output logic                  out_tlast,  // end_of_frame
  input  logic                  cfg_wr_en,
  input  logic                  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic                  in_accept;
  logic                  s1_busy;
  window_t               win;
  stage_ctrl_t           s2;
  pixel_t                res;
  logic                  push;
  logic [OBUF_CNT_W-1:0] obuf_cnt;
  logic [24:0]           pop_data;

  assign in_accept = in_tvalid && in_tready;

  sobel_window #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_addr (cfg_reg_t'(cfg_addr)),
    .cfg_wdata(cfg_wdata),
    .in_accept(in_accept),
    .in_pixel (pixel_t'(in_tdata)),
    .in_sof   (in_tuser),
    .s1_busy  (s1_busy),
    .win      (win),
    .s2_ctrl  (s2)
  );

  always_comb begin
    if (s2.interior) begin
      res.red   = sobel_chan(win[0][0].red, win[0][1].red, win[0][2].red,
                             win[1][0].red, win[1][2].red,
                             win[2][0].red, win[2][1].red, win[2][2].red);
      res.green = sobel_chan(win[0][0].green, win[0][1].green, win[0][2].green,
                             win[1][0].green, win[1][2].green,
                             win[2][0].green, win[2][1].green, win[2][2].green);
      res.blue  = sobel_chan(win[0][0].blue, win[0][1].blue, win[0][2].blue,
                             win[1][0].blue, win[1][2].blue,
                             win[2][0].blue, win[2][1].blue, win[2][2].blue);
    end else begin
      res = win[1][1];
    end
  end

  assign push = s2.valid && s2.emit;

  sobel_out_buf #(.WIDTH(25)) u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data({s2.eof, res}),
    .pop_ready(out_tready),
    .pop_valid(out_tvalid),
    .pop_data (pop_data),
    .count    (obuf_cnt)
  );

  // hold input while queued plus in-flight beats could fill the queue
  assign in_tready = (obuf_cnt + OBUF_CNT_W'(s1_busy) + OBUF_CNT_W'(s2.valid))
                     < OBUF_CNT_W'(OBUF_DEPTH);

  assign out_tdata = pop_data[23:0];
  assign out_tlast = pop_data[24];

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> obuf_cnt < OBUF_CNT_W'(OBUF_DEPTH))
    else $error("result pushed into a full queue");

  a_stage_order: assert property (@(posedge clk) disable iff (!rst_n)
    s2.valid |-> $past(s1_busy))
    else $error("window stage valid without a preceding line-store stage");

  a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> obuf_cnt < OBUF_CNT_W'(OBUF_DEPTH))
    else $error("input ready while the result queue is full");

endmodule

// ----- sv/sobel_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module sobel_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/sobel_window.sv -----
// Frame geometry registers, position counters, the two line-store RAMs and the 3x3 window.
// Depends on sobel_pkg and sobel_ram.
module sobel_window
  import sobel_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  cfg_reg_t              cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_accept,
  input  pixel_t                in_pixel,
  input  logic                  in_sof,
  output logic                  s1_busy,
  output window_t               win,
  output stage_ctrl_t           s2_ctrl
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WCW = $clog2(MAX_WIDTH + 1);
  localparam int HCW = $clog2(MAX_HEIGHT + 3);

  function automatic logic [WCW-1:0] clamp_w(input logic [31:0] raw);
    logic [31:0] v;
    v = raw;
    if (v == 32'd0) v = 32'd1;
    if (v > 32'(MAX_WIDTH)) v = 32'(MAX_WIDTH);
    return v[WCW-1:0];
  endfunction

  function automatic logic [HCW-1:0] clamp_h(input logic [31:0] raw);
    logic [31:0] v;
    v = raw;
    if (v == 32'd0) v = 32'd1;
    if (v > 32'(MAX_HEIGHT)) v = 32'(MAX_HEIGHT);
    return v[HCW-1:0];
  endfunction

  logic [WCW-1:0] w_r;
  logic [HCW-1:0] h_r;
  logic [CW-1:0]  col_r, col_nxt;
  logic [HCW-1:0] row_r, row_nxt;

  logic [CW-1:0]  c0, c_cur;
  logic [HCW-1:0] r0, r_cur, h_p1;
  logic           wrap, idle, last_col, go;

  logic           s1_valid_r;
  logic [CW-1:0]  s1_c_r;
  logic [HCW-1:0] s1_r_r;
  pixel_t         s1_px_r;
  logic           s1_fwd_r;
  pixel_t         fwd_above_r, fwd_two_r;
  logic [23:0]    above_q, two_q;
  pixel_t         px_s1, above_s1, two_s1;

  logic [WCW-1:0] qcol;
  logic [HCW-1:0] qrow;
  logic           emit, interior, eof;

  window_t        win_r, win_nxt;
  stage_ctrl_t    s2_r, s2_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= clamp_w(32'(FRAME_WIDTH_RST));
      h_r <= clamp_h(32'(FRAME_HEIGHT_RST));
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_FRAME_WIDTH:  w_r <= clamp_w(32'(cfg_wdata[WIDTH_REG_W-1:0]));
        REG_FRAME_HEIGHT: h_r <= clamp_h(32'(cfg_wdata[HEIGHT_REG_W-1:0]));
        default: ;
      endcase
    end
  end

  always_comb begin
    c0       = in_sof ? '0 : col_r;
    r0       = in_sof ? '0 : row_r;
    wrap     = WCW'(c0) >= w_r;
    c_cur    = wrap ? '0 : c0;
    r_cur    = wrap ? r0 + 1'b1 : r0;
    h_p1     = h_r + 1'b1;
    idle     = (r_cur > h_p1) || ((r_cur == h_p1) && (c_cur != '0));
    last_col = (WCW'(c_cur) + 1'b1) >= w_r;
    go       = in_accept && !idle;
    if (idle) begin
      col_nxt = c_cur;
      row_nxt = r_cur;
    end else if (last_col) begin
      col_nxt = '0;
      row_nxt = r_cur + 1'b1;
    end else begin
      col_nxt = c_cur + 1'b1;
      row_nxt = r_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  sobel_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_above (
    .clk    (clk),
    .wr_en  (s1_valid_r),
    .wr_addr(s1_c_r),
    .wr_data(px_s1),
    .rd_en  (go),
    .rd_addr(c_cur),
    .rd_data(above_q)
  );

  sobel_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_two_above (
    .clk    (clk),
    .wr_en  (s1_valid_r),
    .wr_addr(s1_c_r),
    .wr_data(above_s1),
    .rd_en  (go),
    .rd_addr(c_cur),
    .rd_data(two_q)
  );

  // forward the write-back that lands on the same edge as the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= go;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      s1_c_r      <= c_cur;
      s1_r_r      <= r_cur;
      s1_px_r     <= in_pixel;
      s1_fwd_r    <= s1_valid_r && (s1_c_r == c_cur);
      fwd_above_r <= px_s1;
      fwd_two_r   <= above_s1;
    end
  end

  always_comb begin
    px_s1    = (s1_r_r < h_r) ? s1_px_r : '0;
    above_s1 = s1_fwd_r ? fwd_above_r : pixel_t'(above_q);
    two_s1   = s1_fwd_r ? fwd_two_r : pixel_t'(two_q);

    emit = (s1_r_r >= HCW'(2)) || ((s1_r_r == HCW'(1)) && (s1_c_r != '0));
    if (s1_c_r != '0) begin
      qcol = WCW'(s1_c_r) - 1'b1;
      qrow = s1_r_r - 1'b1;
    end else begin
      qcol = w_r - 1'b1;
      qrow = s1_r_r - HCW'(2);
    end
    interior = (qrow != '0) && (({1'b0, qrow} + (HCW+1)'(2)) <= {1'b0, h_r})
            && (qcol != '0) && (({1'b0, qcol} + (WCW+1)'(2)) <= {1'b0, w_r});
    eof = (qrow == h_r - 1'b1) && (qcol == w_r - 1'b1);

    for (int i = 0; i < 3; i++) begin
      win_nxt[i][0] = win_r[i][1];
      win_nxt[i][1] = win_r[i][2];
    end
    win_nxt[0][2] = two_s1;
    win_nxt[1][2] = above_s1;
    win_nxt[2][2] = px_s1;

    s2_nxt.valid    = s1_valid_r;
    s2_nxt.emit     = emit;
    s2_nxt.interior = interior;
    s2_nxt.eof      = eof;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
      s2_r  <= '0;
    end else begin
      s2_r <= s2_nxt;
      if (s1_valid_r) begin
        win_r <= win_nxt;
      end
    end
  end

  assign s1_busy = s1_valid_r;
  assign win     = win_r;
  assign s2_ctrl = s2_r;

endmodule

// ----- sv/sobel_out_buf.sv -----
// Small result queue that decouples the filter pipeline from output backpressure.
// Depends on sobel_pkg.
module sobel_out_buf
  import sobel_pkg::*;
#(
  parameter int WIDTH = 25
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [WIDTH-1:0]      push_data,
  input  logic                  pop_ready,
  output logic                  pop_valid,
  output logic [WIDTH-1:0]      pop_data,
  output logic [OBUF_CNT_W-1:0] count
);

  localparam int PW = $clog2(OBUF_DEPTH);

  logic [WIDTH-1:0]      mem_r [OBUF_DEPTH];
  logic [PW-1:0]         wr_ptr_r, rd_ptr_r;
  logic [OBUF_CNT_W-1:0] cnt_r;
  logic                  pop;

  assign pop = (cnt_r != '0) && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  assign pop_valid = cnt_r != '0;
  assign pop_data  = mem_r[rd_ptr_r];
  assign count     = cnt_r;

endmodule
